>>> sv/fqks_pkg.sv
// Shared constants, operation and status codes, and a pointer helper for the key-search queue.
package fqks_pkg;

  // Number of entries the queue can hold.
  localparam int DEPTH = 16;

  // Ring pointer and occupancy widths follow from the depth.
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Field widths of one transfer.
  localparam int OP_W     = 2;
  localparam int CODE_W   = 32;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 5;
  localparam int ENTRY_W  = CODE_W + VALUE_W;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // Advance a ring pointer, wrapping after the last slot.
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] nxt;
    if (p == PTR_W'(DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = p + PTR_W'(1);
    end
    return nxt;
  endfunction

endpackage

>>> sv/fqks_req_if.sv
// Request channel interface: operation, code and value with a valid/ready handshake.
interface fqks_req_if
  import fqks_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [CODE_W-1:0] entry_code;
  logic [VALUE_W-1:0]       entry_value;

  modport source (output valid, operation, entry_code, entry_value, input ready);
  modport sink (input valid, operation, entry_code, entry_value, output ready);
endinterface

>>> sv/fqks_rsp_if.sv
// Response channel interface: status, position, count and removed entry with valid/ready.
interface fqks_rsp_if
  import fqks_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [POS_W-1:0]         found_position;
  logic [POS_W-1:0]         entry_count;
  logic signed [CODE_W-1:0] removed_code;
  logic [VALUE_W-1:0]       removed_value;

  modport source (output valid, status, found_position, entry_count, removed_code,
                  removed_value, input ready);
  modport sink (input valid, status, found_position, entry_count, removed_code,
                removed_value, output ready);
endinterface

>>> sv/fqks_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module fqks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read share the clock edge.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/fifo_queue_with_key_search_core.sv
// Bounded FIFO queue of code/value entries held in a ring RAM, with linear key search.
//
//   channel | role | carries
//   --------+------+--------------------------------------------------------------
//   req     | sink | operation, entry_code, entry_value
//   rsp     | src  | status, found_position, entry_count, removed_code, removed_value
//
// Push and rejected operations pass from the transfer through the emit step to the result;
// pop adds a step that captures the head entry. Search walks the entries until the match
// or the occupancy is reached; the single RAM read port reads one entry a cycle.
// Reset (rst, synchronous) empties the queue; the RAM itself is not cleared.
// A new request is taken while a finished result still waits in the output register;
// the next result waits for that register to empty.
module fifo_queue_with_key_search_core
  import fqks_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  fqks_req_if.sink   req,
  fqks_rsp_if.source rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SEARCH,
    S_EMIT
  } state_t;

  state_t state;

  // Queue pointers and occupancy.
  logic [PTR_W-1:0] head_ptr;
  logic [PTR_W-1:0] tail_ptr;
  logic [CNT_W-1:0] count;

  // Search walk registers.
  logic [PTR_W-1:0]         scan_ptr;
  logic [CNT_W-1:0]         idx;
  logic signed [CODE_W-1:0] key;

  // Result being built, and the output register.
  logic [STATUS_W-1:0]      res_status;
  logic [POS_W-1:0]         res_pos;
  logic signed [CODE_W-1:0] res_code;
  logic [VALUE_W-1:0]       res_value;
  logic                     out_valid;

  // RAM ports.
  logic                 ram_we;
  logic [PTR_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [PTR_W-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;

  logic accept;
  logic is_empty;
  logic is_full;
  logic hit;
  logic out_free;

  assign accept   = req.valid && req.ready;
  assign is_empty = (count == '0);
  assign is_full  = (count == CNT_W'(DEPTH));
  assign hit      = (ram_rdata[ENTRY_W-1:VALUE_W] == key);
  assign out_free = !out_valid || rsp.ready;

  assign req.ready = (state == S_IDLE);

  // A push writes at the tail in the transfer cycle.
  assign ram_we    = accept && (req.operation == OP_PUSH) && !is_full;
  assign ram_waddr = tail_ptr;
  assign ram_wdata = {req.entry_code, req.entry_value};

  // The walk reads ahead from scan_ptr; otherwise the head is read.
  assign ram_raddr = (state == S_SEARCH) ? scan_ptr : head_ptr;

  fqks_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer: holds state, pointers and the registered response.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head_ptr  <= '0;
      tail_ptr  <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // The output register drains on a transfer unless refilled below.
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_status <= ST_OK;
            res_pos    <= '0;
            res_code   <= '0;
            res_value  <= '0;
            unique case (req.operation)
              OP_PUSH: begin
                if (is_full) begin
                  res_status <= ST_FULL;
                end else begin
                  tail_ptr <= ptr_inc(tail_ptr);
                  count    <= count + CNT_W'(1);
                end
                state <= S_EMIT;
              end
              OP_POP: begin
                if (is_empty) begin
                  res_status <= ST_EMPTY;
                  state      <= S_EMIT;
                end else begin
                  head_ptr <= ptr_inc(head_ptr);
                  count    <= count - CNT_W'(1);
                  state    <= S_POP;
                end
              end
              OP_SEARCH: begin
                if (is_empty) begin
                  res_status <= ST_EMPTY;
                  state      <= S_EMIT;
                end else begin
                  res_status <= ST_NOTFOUND;
                  key        <= req.entry_code;
                  idx        <= '0;
                  scan_ptr   <= ptr_inc(head_ptr);
                  state      <= S_SEARCH;
                end
              end
              default: begin
                state <= S_EMIT;
              end
            endcase
          end
        end

        // Capture the old head entry read in the transfer cycle.
        S_POP: begin
          res_code  <= ram_rdata[ENTRY_W-1:VALUE_W];
          res_value <= ram_rdata[VALUE_W-1:0];
          state     <= S_EMIT;
        end

        // Compare one entry a cycle while the next one is being read.
        S_SEARCH: begin
          if (hit) begin
            res_status <= ST_OK;
            res_pos    <= POS_W'(idx + CNT_W'(1));
            state      <= S_EMIT;
          end else if ((idx + CNT_W'(1)) == count) begin
            state <= S_EMIT;
          end else begin
            idx      <= idx + CNT_W'(1);
            scan_ptr <= ptr_inc(scan_ptr);
          end
        end

        // Load the output register once it is free.
        S_EMIT: begin
          if (out_free) begin
            rsp.status         <= res_status;
            rsp.found_position <= res_pos;
            rsp.entry_count    <= POS_W'(count);
            rsp.removed_code   <= res_code;
            rsp.removed_value  <= res_value;
            out_valid          <= 1'b1;
            state              <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid = out_valid;

`ifndef SYNTH
  // Occupancy never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("occupancy above capacity");

  // An empty or full ring has head and tail at the same slot.
  a_ptr_meet: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == CNT_W'(DEPTH)) |-> (head_ptr == tail_ptr))
    else $error("head and tail disagree with occupancy");

  // The search walk stays inside the occupied entries.
  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (idx < count))
    else $error("search walked past the tail");

  // A new response only appears out of the emit step.
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EMIT))
    else $error("response raised outside emit");
`endif

endmodule

>>> tb/sv/fifo_queue_with_key_search_core_test.sv
// Self-checking testbench for the key-search queue: random push, pop and search traffic.
module fifo_queue_with_key_search_core_test;
  import fqks_pkg::*;

  // Operation code 3 has no function and must leave the queue untouched.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 550;
  localparam int unsigned MAX_REPORTS = 10;

  // One response as seen on the response channel.
  typedef struct {
    logic [STATUS_W-1:0]      status;
    logic [POS_W-1:0]         found_position;
    logic [POS_W-1:0]         entry_count;
    logic signed [CODE_W-1:0] removed_code;
    logic [VALUE_W-1:0]       removed_value;
  } queue_result_t;

  // Shadow copy of the queue contents plus the responses still owed by the block.
  class queue_shadow;
    logic signed [CODE_W-1:0] codes[DEPTH];
    logic [VALUE_W-1:0]       values[DEPTH];
    int unsigned              head;
    int unsigned              tail;
    int unsigned              held;
    queue_result_t            owed_results[$];
    int unsigned              errors;
    int unsigned              results_seen;
    int unsigned              full_rejects;
    int unsigned              empty_rejects;
    int unsigned              search_hits;
    int unsigned              search_misses;
    int unsigned              deepest_hit;

    function new();
      head = 0;
      tail = 0;
      held = 0;
      errors = 0;
      results_seen = 0;
      full_rejects = 0;
      empty_rejects = 0;
      search_hits = 0;
      search_misses = 0;
      deepest_hit = 0;
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    // Pick the code of an entry now held, so that searches find something.
    function logic signed [CODE_W-1:0] held_code();
      return codes[(head + $urandom_range(0, held - 1)) % DEPTH];
    endfunction

    function bit i_deeper(input logic [POS_W-1:0] pos);
      return int'(pos) > deepest_hit;
    endfunction

    // Apply one accepted request to the shadow queue and queue its response.
    function void note_request(input logic [OP_W-1:0] op,
                               input logic signed [CODE_W-1:0] code,
                               input logic [VALUE_W-1:0] value);
      queue_result_t res;
      int unsigned   idx;
      res.status = ST_OK;
      res.found_position = '0;
      res.removed_code = '0;
      res.removed_value = '0;
      case (op)
        OP_PUSH: begin
          if (held >= DEPTH) begin
            res.status = ST_FULL;
            full_rejects++;
          end else begin
            codes[tail] = code;
            values[tail] = value;
            tail = (tail + 1) % DEPTH;
            held++;
          end
        end
        OP_POP: begin
          if (held == 0) begin
            res.status = ST_EMPTY;
            empty_rejects++;
          end else begin
            res.removed_code = codes[head];
            res.removed_value = values[head];
            head = (head + 1) % DEPTH;
            held--;
          end
        end
        OP_SEARCH: begin
          if (held == 0) begin
            res.status = ST_EMPTY;
            empty_rejects++;
          end else begin
            res.status = ST_NOTFOUND;
            for (int unsigned i = 0; i < held; i++) begin
              idx = (head + i) % DEPTH;
              if (codes[idx] == code) begin
                res.status = ST_OK;
                res.found_position = POS_W'(i + 1);
                break;
              end
            end
            if (res.status == ST_OK) begin
              search_hits++;
              if (i_deeper(res.found_position)) deepest_hit = 32'(res.found_position);
            end else begin
              search_misses++;
            end
          end
        end
        default: begin
          // Unused operation: nothing changes.
        end
      endcase
      res.entry_count = POS_W'(held);
      owed_results.push_back(res);
    endfunction

    // Compare one response transfer with the oldest owed response.
    function void check_response(input queue_result_t got);
      queue_result_t want;
      results_seen++;
      if (owed_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("[%0t] unexpected response: status=%0d pos=%0d count=%0d code=%h value=%h",
                   $time, got.status, got.found_position, got.entry_count,
                   got.removed_code, got.removed_value);
        end
        return;
      end
      want = owed_results.pop_front();
      if (got.status !== want.status || got.found_position !== want.found_position ||
          got.entry_count !== want.entry_count || got.removed_code !== want.removed_code ||
          got.removed_value !== want.removed_value) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("[%0t] response %0d mismatch", $time, results_seen);
          $display("  expected: status=%0d pos=%0d count=%0d code=%h value=%h",
                   want.status, want.found_position, want.entry_count,
                   want.removed_code, want.removed_value);
          $display("  actual:   status=%0d pos=%0d count=%0d code=%h value=%h",
                   got.status, got.found_position, got.entry_count,
                   got.removed_code, got.removed_value);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  bit          quiet = 1'b0;
  int unsigned transfers_sent = 0;
  queue_shadow shadow = new();

  fqks_req_if req();
  fqks_rsp_if rsp();

  fifo_queue_with_key_search_core dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // Free-running clock, period 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle gap before a request: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Codes from a narrow band give duplicates; full-width codes exercise every bit.
  function automatic logic signed [CODE_W-1:0] pick_code();
    if ($urandom_range(0, 1) == 0) return CODE_W'($signed($urandom_range(0, 7)) - 4);
    return $urandom();
  endfunction

  function automatic logic signed [CODE_W-1:0] pick_search_code();
    if (shadow.held > 0 && $urandom_range(0, 9) < 7) return shadow.held_code();
    return pick_code();
  endfunction

  // Present one request and hold it until the block takes the transfer.
  task automatic send_request(input logic [OP_W-1:0] op,
                              input logic signed [CODE_W-1:0] code,
                              input logic [VALUE_W-1:0] value);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.operation <= op;
    req.entry_code <= code;
    req.entry_value <= value;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    shadow.note_request(op, code, value);
    transfers_sent++;
  endtask

  // Response side: random back-pressure, and a check on every transfer.
  initial begin
    int unsigned   stall;
    queue_result_t got;
    stall = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        rsp.ready <= 1'b0;
      end else begin
        if (rsp.valid && rsp.ready) begin
          got.status = rsp.status;
          got.found_position = rsp.found_position;
          got.entry_count = rsp.entry_count;
          got.removed_code = rsp.removed_code;
          got.removed_value = rsp.removed_value;
          shadow.check_response(got);
        end
        if (stall > 0) begin
          stall--;
          rsp.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
          stall = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(4, 29);
          rsp.ready <= 1'b0;
        end else begin
          rsp.ready <= 1'b1;
        end
      end
    end
  end

  // Main stimulus: reset, directed corner cases, then random bursts.
  initial begin
    int unsigned n;
    int unsigned mode;
    int unsigned r;
    logic [OP_W-1:0] op;
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.operation <= OP_PUSH;
    req.entry_code <= '0;
    req.entry_value <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Operations on an empty queue.
    send_request(OP_POP, 32'sd0, 32'h0);
    send_request(OP_SEARCH, 32'sd0, 32'h0);
    send_request(OP_UNUSED, 32'h7fff_ffff, 32'hffff_ffff);
    // Extreme codes and values, with a duplicate code.
    send_request(OP_PUSH, 32'h8000_0000, 32'h0000_0000);
    send_request(OP_PUSH, 32'h7fff_ffff, 32'hffff_ffff);
    send_request(OP_PUSH, -32'sd1, 32'h3f80_0000);
    send_request(OP_PUSH, 32'h7fff_ffff, 32'h0000_0001);
    // The first match wins; a code that is absent reports not found.
    send_request(OP_SEARCH, 32'h7fff_ffff, 32'h0);
    send_request(OP_SEARCH, -32'sd1, 32'h0);
    send_request(OP_SEARCH, 32'h8000_0000, 32'h0);
    send_request(OP_SEARCH, 32'sd12345, 32'h0);
    send_request(OP_UNUSED, 32'h8000_0000, 32'h0);
    send_request(OP_POP, 32'sd0, 32'h0);
    send_request(OP_POP, 32'sd0, 32'h0);
    send_request(OP_SEARCH, 32'h7fff_ffff, 32'h0);

    // Random bursts: fills that run into full, drains that run into empty,
    // search runs over a loaded queue, and mixed traffic.
    while (transfers_sent < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 9);
      quiet = ($urandom_range(0, 5) == 0);
      if (mode < 3) begin
        n = $urandom_range(1, DEPTH + 3);
        repeat (n) send_request(OP_PUSH, pick_code(), $urandom());
      end else if (mode < 5) begin
        n = $urandom_range(1, DEPTH + 3);
        repeat (n) send_request(OP_POP, pick_code(), $urandom());
      end else if (mode < 8) begin
        n = $urandom_range(1, 6);
        repeat (n) send_request(OP_SEARCH, pick_search_code(), $urandom());
      end else begin
        n = $urandom_range(1, 10);
        repeat (n) begin
          r = $urandom_range(0, 19);
          op = (r == 0) ? OP_UNUSED : (r < 8) ? OP_PUSH : (r < 13) ? OP_POP : OP_SEARCH;
          send_request(op, (op == OP_SEARCH) ? pick_search_code() : pick_code(), $urandom());
        end
      end
    end
    quiet = 1'b0;

    // Drain, then give the block time to show any stray response.
    req.valid <= 1'b0;
    while (shadow.pending() > 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);

    $display("Ran %0d transfers: %0d full rejects, %0d empty rejects.",
             transfers_sent, shadow.full_rejects, shadow.empty_rejects);
    $display("Searches: %0d hits (deepest position %0d), %0d misses.",
             shadow.search_hits, shadow.deepest_hit, shadow.search_misses);
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches.", shadow.errors);
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5000000;
    $display("Timeout with %0d responses outstanding.", shadow.pending());
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> filelist.f
sv/fqks_pkg.sv
sv/fqks_req_if.sv
sv/fqks_rsp_if.sv
sv/fqks_ram.sv
sv/fifo_queue_with_key_search_core.sv
tb/sv/fifo_queue_with_key_search_core_test.sv
